// ===== hw/rtl/fir_filter_circular_history_defines.svh =====
// assertion helpers used by fch_checker
`ifndef FIR_FILTER_CIRCULAR_HISTORY_DEFINES_SVH
`define FIR_FILTER_CIRCULAR_HISTORY_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FCH_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define FCH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fch_pkg.sv =====
package fch_pkg;

    localparam int MAX_TAPS_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_W          = 16;
    localparam int TAPCNT_W        = 11;
    localparam int TAPIDX_W        = 10;
    localparam int OUT_W           = 42;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_PUSH = 1'b1
    } t_op;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic load;
        logic push;
        logic mac_step;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic mac_last;
        logic pipe_busy;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hw/rtl/fch_intf.sv =====
interface fch_in_if import fch_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [TAPIDX_W-1:0]           tap_index;
    logic signed [COEF_W-1:0]      coefficient;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output operation, output tap_index,
                    output coefficient, output sample, input ready);
    modport sink   (input valid, input operation, input tap_index,
                    input coefficient, input sample, output ready);
endinterface

interface fch_out_if import fch_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

interface fch_cfg_if import fch_pkg::*;;
    logic                valid;
    logic                ready;
    logic [TAPCNT_W-1:0] tap_count;

    modport source (output valid, output tap_count, input ready);
    modport sink   (input valid, input tap_count, output ready);
endinterface

// ===== hw/rtl/fch_ctrl.sv =====
module fch_ctrl import fch_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_op,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_MAC   = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == OP_PUSH) begin
                        o_cmd.push = 1'b1;
                        n_state    = S_MAC;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_MAC: begin
                o_cmd.mac_step = 1'b1;
                if (i_sts.mac_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // wait for the last product to land and the output slot to free up
                if (!i_sts.pipe_busy && i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/fch_datapath.sv =====
module fch_datapath import fch_pkg::*; #(
    parameter int MAX_TAPS    = MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_sts                       o_sts,
    input  logic [TAPIDX_W-1:0]           i_tap_index,
    input  logic signed [COEF_W-1:0]      i_coefficient,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_cfg_valid,
    input  logic [TAPCNT_W-1:0]           i_cfg_tap_count,
    output logic                          o_cfg_ready,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [OUT_W-1:0]       o_out_filtered
);

    localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW    = $clog2(MAX_TAPS + 1);
    localparam int PW    = SAMPLE_BITS + COEF_W;
    localparam int ACC_W = (PW > OUT_W) ? PW : OUT_W;

    logic signed [SAMPLE_BITS-1:0] r_hist_mem [MAX_TAPS];
    logic signed [COEF_W-1:0]      r_coef_mem [MAX_TAPS];

    logic [CW-1:0]                 r_taps;
    logic [AW-1:0]                 r_wr_pos;
    logic [AW-1:0]                 r_clr_addr;
    logic [AW-1:0]                 r_hist_idx;
    logic [CW-1:0]                 r_coef_idx;
    logic                          r_rd_vld;
    logic                          r_mul_vld;
    logic signed [SAMPLE_BITS-1:0] r_hist_q;
    logic signed [COEF_W-1:0]      r_coef_q;
    logic signed [PW-1:0]          r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic                          r_out_vld;
    logic signed [OUT_W-1:0]       r_out_data;

    logic [CW-1:0]                 cfg_taps;
    logic [AW-1:0]                 pos;
    logic [CW-1:0]                 pos_inc;
    logic [AW-1:0]                 next_pos;
    logic [AW-1:0]                 last_idx;
    logic                          hist_we;
    logic [AW-1:0]                 hist_waddr;
    logic signed [SAMPLE_BITS-1:0] hist_wdata;
    logic                          coef_we;

    always_comb begin
        // tap count of zero runs one tap, large counts saturate
        if (i_cfg_tap_count == '0) begin
            cfg_taps = CW'(1);
        end else if (int'(i_cfg_tap_count) > MAX_TAPS) begin
            cfg_taps = CW'(MAX_TAPS);
        end else begin
            cfg_taps = CW'(i_cfg_tap_count);
        end

        // a stale position past a shrunk tap count restarts at zero
        pos      = (CW'(r_wr_pos) < r_taps) ? r_wr_pos : '0;
        pos_inc  = CW'(pos) + CW'(1);
        next_pos = (pos_inc >= r_taps) ? '0 : AW'(pos_inc);
        last_idx = AW'(r_taps - CW'(1));

        hist_we    = i_cmd.clear_wr | i_cmd.push;
        hist_waddr = i_cmd.clear_wr ? r_clr_addr : pos;
        hist_wdata = i_cmd.clear_wr ? '0 : i_sample;
        coef_we    = i_cmd.load && (int'(i_tap_index) < MAX_TAPS);
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist_mem[hist_waddr] <= hist_wdata;
        end
        r_hist_q <= r_hist_mem[r_hist_idx];
    end

    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            r_coef_mem[AW'(i_tap_index)] <= i_coefficient;
        end
        r_coef_q <= r_coef_mem[r_coef_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps     <= CW'(1);
            r_wr_pos   <= '0;
            r_clr_addr <= '0;
            r_rd_vld   <= 1'b0;
            r_mul_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_taps <= cfg_taps;
            end
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.push) begin
                r_wr_pos <= next_pos;
            end
            r_rd_vld  <= i_cmd.mac_step;
            r_mul_vld <= r_rd_vld;
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            // first read is the sample just written
            r_hist_idx <= pos;
            r_coef_idx <= '0;
        end else if (i_cmd.mac_step) begin
            r_hist_idx <= (r_hist_idx == '0) ? last_idx : r_hist_idx - AW'(1);
            r_coef_idx <= r_coef_idx + CW'(1);
        end
        r_prod <= r_hist_q * r_coef_q;
        if (i_cmd.push) begin
            r_acc <= '0;
        end else if (r_mul_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.out_load) begin
            r_out_data <= r_acc[OUT_W-1:0];
        end
    end

    always_comb begin
        o_sts.clear_last = (r_clr_addr == AW'(MAX_TAPS - 1));
        o_sts.mac_last   = (r_coef_idx == r_taps - CW'(1));
        o_sts.pipe_busy  = r_rd_vld | r_mul_vld;
        o_sts.out_free   = !r_out_vld || i_out_ready;
    end

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_vld;
    assign o_out_filtered = r_out_data;

endmodule

// ===== hw/rtl/fir_filter_circular_history.sv =====
// direct-form fir filter over a circular sample history
// i_in carries two kinds of request: operation 0 loads a q1.15 coefficient
// at tap_index, operation 1 pushes a q1.15 sample; only a push gives a result
// o_out gives one q12.30 sum per push; i_cfg sets the tap count at any time
// the block is idle (it is always ready)
// after reset the history memory is swept to zero, one entry a cycle, so
// i_in stays not ready until the sweep ends; the tap count resets to one
// a load leaves i_in ready; after a push i_in drops ready while one shared
// multiply-accumulate reads one history and one coefficient entry a cycle
// over the taps in use, then until the read, multiply and accumulate pipeline
// registers drain and the output register is free
// the result shows on o_out from an output register once the pipeline has
// drained and is held there while o_out.ready is low; loads go on meanwhile,
// but the next push waits before its result if that register is still full
// coefficients must be loaded before a push reads them
module fir_filter_circular_history import fch_pkg::*; #(
    parameter int MAX_TAPS    = MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fch_in_if.sink    i_in,
    fch_out_if.source o_out,
    fch_cfg_if.sink   i_cfg
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    fch_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.operation),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    fch_datapath #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_tap_index     (i_in.tap_index),
        .i_coefficient   (i_in.coefficient),
        .i_sample        (i_in.sample),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_tap_count (i_cfg.tap_count),
        .o_cfg_ready     (i_cfg.ready),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_out_filtered  (o_out.filtered)
    );

endmodule

// ===== hw/rtl/fch_checker.sv =====
`include "fir_filter_circular_history_defines.svh"

module fch_checker import fch_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_in_op,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [OUT_W-1:0] i_out_filtered
);

    // history sweep follows reset
    `FCH_ASSERT_SAME(a_clear_after_reset, i_clk, i_rst_n, $rose(i_rst_n), !i_in_ready, "ready during clear sweep")

    // a push occupies the multiply-accumulate
    `FCH_ASSERT_NEXT(a_push_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_op == OP_PUSH), !i_in_ready, "ready right after a push")

    // a load never produces a result
    `FCH_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_op == OP_LOAD) && !i_out_valid, !i_out_valid, "result after a load")

    `FCH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_filtered), "stalled result changed")

endmodule

bind fir_filter_circular_history fch_checker u_fch_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_op        (i_in.operation),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_filtered (o_out.filtered)
);

// ===== verif/fir_filter_circular_history_checker.sv =====
module fir_filter_circular_history_checker import fch_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    fch_in_if    i_in_ch,
    fch_out_if   i_res_ch,
    fch_cfg_if   i_cfg_ch,
    output int   o_mismatches,
    output int   o_pending
);

    logic signed [SAMPLE_BITS_DEF-1:0] history [MAX_TAPS_DEF];
    logic signed [COEF_W-1:0]          coefs   [MAX_TAPS_DEF];
    logic [TAPIDX_W-1:0]               wr_pos;
    logic [TAPCNT_W-1:0]               taps_reg;
    logic signed [OUT_W-1:0]           filtered_q [$];
    logic signed [OUT_W-1:0]           want;
    int                                mismatches = 0;

    function automatic int taps_in_use();
        if (taps_reg == '0) return 1;
        if (int'(taps_reg) > MAX_TAPS_DEF) return MAX_TAPS_DEF;
        return int'(taps_reg);
    endfunction

    // store the sample, advance the position, then sum newest-first
    function automatic logic signed [OUT_W-1:0] filter_push(
        logic signed [SAMPLE_BITS_DEF-1:0] smp
    );
        int     n;
        int     pos;
        int     idx;
        longint acc;
        n = taps_in_use();
        // position left beyond a shrunk tap count restarts at zero
        pos = (int'(wr_pos) < n) ? int'(wr_pos) : 0;
        history[pos] = smp;
        pos++;
        if (pos >= n) pos = 0;
        wr_pos = TAPIDX_W'(pos);
        acc = 0;
        idx = pos;
        for (int i = 0; i < n; i++) begin
            idx = (idx != 0) ? idx - 1 : n - 1;
            acc += longint'(history[idx]) * longint'(coefs[i]);
        end
        return acc[OUT_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (history[i]) begin
                history[i] = '0;
                coefs[i]   = '0;
            end
            wr_pos   = '0;
            taps_reg = TAPCNT_W'(1);
            filtered_q.delete();
        end else begin
            if (i_cfg_ch.valid && i_cfg_ch.ready) taps_reg = i_cfg_ch.tap_count;
            if (i_in_ch.valid && i_in_ch.ready) begin
                if (i_in_ch.operation == OP_PUSH)
                    filtered_q.push_back(filter_push(i_in_ch.sample));
                else
                    coefs[i_in_ch.tap_index] = i_in_ch.coefficient;
            end
            if (i_res_ch.valid && i_res_ch.ready) begin
                if (filtered_q.size() == 0) begin
                    $error("filtered: no request waiting, actual %0d", i_res_ch.filtered);
                    mismatches++;
                end else begin
                    want = filtered_q.pop_front();
                    if (i_res_ch.filtered !== want) begin
                        $error("filtered mismatch: expected %0d, actual %0d",
                               want, i_res_ch.filtered);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= filtered_q.size();
        o_mismatches <= mismatches;
    end

endmodule

// ===== verif/fir_filter_circular_history_tb.sv =====
module fir_filter_circular_history_tb;
    import fch_pkg::*;

    localparam int CYCLE_LIMIT   = 3000000;
    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_ITEMS  = 560;
    localparam int STEADY_FROM   = 480;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fch_in_if  in_ch ();
    fch_out_if res_ch ();
    fch_cfg_if cfg_ch ();

    int mismatches;
    int pending;
    int cycles = 0;
    bit steady = 1'b0;
    bit coef_loaded [MAX_TAPS_DEF];
    int taps_now = 1;
    int rand_items = 0;
    int phase = 0;
    int burst;

    fir_filter_circular_history DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    fir_filter_circular_history_checker filter_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_res_ch     (res_ch),
        .i_cfg_ch     (cfg_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side backpressure
    initial begin
        int stall;
        stall = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (steady) begin
                res_ch.ready <= 1'b1;
            end else if (stall > 0) begin
                res_ch.ready <= 1'b0;
                stall--;
            end else if ($urandom_range(0, 4) == 0) begin
                res_ch.ready <= 1'b0;
                stall = $urandom_range(0, 3);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic signed [COEF_W-1:0] rand_q15();
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return '0;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic logic [TAPCNT_W-1:0] pick_taps(int ph);
        int r;
        if (ph == 1) return TAPCNT_W'(2047);
        if (ph == 3) return TAPCNT_W'(MAX_TAPS_DEF);
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return TAPCNT_W'(1);
        if (r == 2) return TAPCNT_W'($urandom_range(65, 2047));
        if (r < 9) return TAPCNT_W'($urandom_range(2, 64));
        return TAPCNT_W'($urandom_range(0, 15) * 2 + 1);
    endfunction

    // leaves valid high after acceptance so back-to-back requests need no gap
    task automatic send_req(t_op op, logic [TAPIDX_W-1:0] idx,
                            logic signed [COEF_W-1:0] coef,
                            logic signed [SAMPLE_BITS_DEF-1:0] smp);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= op;
        in_ch.tap_index   <= idx;
        in_ch.coefficient <= coef;
        in_ch.sample      <= smp;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic load_coef(logic [TAPIDX_W-1:0] idx, logic signed [COEF_W-1:0] coef);
        send_req(OP_LOAD, idx, coef, rand_q15());
        coef_loaded[idx] = 1'b1;
    endtask

    task automatic push_sample(logic signed [SAMPLE_BITS_DEF-1:0] smp);
        send_req(OP_PUSH, TAPIDX_W'($urandom), rand_q15(), smp);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // a trailing load or the tail of a push may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_taps(logic [TAPCNT_W-1:0] value);
        drain_results();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.tap_count <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (value == '0) taps_now = 1;
        else if (int'(value) > MAX_TAPS_DEF) taps_now = MAX_TAPS_DEF;
        else taps_now = int'(value);
        // every slot a push will read must hold a loaded coefficient
        for (int i = 0; i < taps_now; i++)
            if (!coef_loaded[i]) load_coef(TAPIDX_W'(i), rand_q15());
    endtask

    initial begin
        foreach (coef_loaded[i]) coef_loaded[i] = 1'b0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.operation   <= OP_LOAD;
        in_ch.tap_index   <= '0;
        in_ch.coefficient <= '0;
        in_ch.sample      <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.tap_count  <= TAPCNT_W'(1);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one tap after reset: products at the corners of the range
        load_coef('0, 16'sh7fff);
        push_sample(16'sh7fff);
        push_sample(16'sh8000);
        load_coef('0, 16'sh8000);
        push_sample(16'sh8000);
        push_sample(16'sh7fff);
        push_sample('0);
        load_coef(TAPIDX_W'(1023), 16'sh7fff);
        load_coef(TAPIDX_W'(1), 16'sh8000);
        load_coef(TAPIDX_W'(2), 16'sh1234);

        // leave the write position at four, then shrink below it
        set_taps(TAPCNT_W'(5));
        repeat (4) push_sample(rand_q15());
        set_taps(TAPCNT_W'(3));
        repeat (2) push_sample(rand_q15());
        // zero taps behaves as one
        set_taps('0);
        repeat (2) push_sample(rand_q15());

        while (rand_items < RANDOM_ITEMS) begin
            set_taps(pick_taps(phase));
            burst = (taps_now > 64) ? $urandom_range(4, 8) : $urandom_range(20, 60);
            repeat (burst) begin
                if (rand_items >= STEADY_FROM) steady = 1'b1;
                if ($urandom_range(0, 9) < 3)
                    load_coef(TAPIDX_W'($urandom), rand_q15());
                else
                    push_sample(rand_q15());
                rand_items++;
                if (!steady && $urandom_range(0, 49) == 0) drain_results();
            end
            phase++;
        end

        drain_results();
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
